/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the point extractor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/ocpe_pkg.sv */
// ----------------------------------------------------------------------------
// ocpe_pkg
// Types and constants of the occupied cell point extractor.
// ----------------------------------------------------------------------------
package ocpe_pkg;

   localparam int GRID_DIM_MAX  = 4096;
   localparam int IDX_W         = $clog2(GRID_DIM_MAX);
   localparam int SCAN_W        = IDX_W + 1;
   localparam int GRID_WIDTH_W  = 13;
   localparam int RSP_IDX_W     = 12;
   localparam int COORD_W       = 32;
   localparam int CELL_W        = 8;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RESET = GRID_WIDTH_W'(1);
   localparam logic signed [CELL_W-1:0] THRESHOLD_RESET = CELL_W'(100);
   localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(GRID_DIM_MAX - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH    = 3'd0,
      CSR_THRESHOLD     = 3'd1,
      CSR_BASE_X        = 3'd2,
      CSR_BASE_Y        = 3'd3,
      CSR_COLUMN_STEP_X = 3'd4,
      CSR_COLUMN_STEP_Y = 3'd5,
      CSR_ROW_STEP_X    = 3'd6,
      CSR_ROW_STEP_Y    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] cell_value;
      logic                     frame_start;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [RSP_IDX_W-1:0]      cell_column;
      logic [RSP_IDX_W-1:0]      cell_row;
   } rsp_type;

   typedef struct packed {
      logic [GRID_WIDTH_W-1:0]  grid_width;
      logic signed [CELL_W-1:0] hit_level;
      logic [COORD_W-1:0]       base_x;
      logic [COORD_W-1:0]       base_y;
      logic [COORD_W-1:0]       column_step_x;
      logic [COORD_W-1:0]       column_step_y;
      logic [COORD_W-1:0]       row_step_x;
      logic [COORD_W-1:0]       row_step_y;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{grid_width: GRID_WIDTH_RESET,
                                     hit_level: THRESHOLD_RESET,
                                     default: '0};

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] column;
      logic [IDX_W-1:0] row;
   } cell_stage_type;

endpackage

/* rtl/core/ocpe_csr.sv */
// ----------------------------------------------------------------------------
// ocpe_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module ocpe_csr
   import ocpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:    cfg_in.grid_width = csr_write_data[GRID_WIDTH_W-1:0];
            CSR_THRESHOLD:     cfg_in.hit_level = csr_write_data[CELL_W-1:0];
            CSR_BASE_X:        cfg_in.base_x = csr_write_data[COORD_W-1:0];
            CSR_BASE_Y:        cfg_in.base_y = csr_write_data[COORD_W-1:0];
            CSR_COLUMN_STEP_X: cfg_in.column_step_x = csr_write_data[COORD_W-1:0];
            CSR_COLUMN_STEP_Y: cfg_in.column_step_y = csr_write_data[COORD_W-1:0];
            CSR_ROW_STEP_X:    cfg_in.row_step_x = csr_write_data[COORD_W-1:0];
            CSR_ROW_STEP_Y:    cfg_in.row_step_y = csr_write_data[COORD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/ocpe_scan.sv */
// ----------------------------------------------------------------------------
// ocpe_scan
// Raster scan counters, occupancy test and the registered cell stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ocpe_scan
   import ocpe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   input  cfg_type        cfg,
   input  logic           advance,
   output cell_stage_type stage
);

   logic [IDX_W-1:0]  scan_column_ff, scan_column_in;
   logic [IDX_W-1:0]  scan_row_ff, scan_row_in;
   cell_stage_type    stage_ff, stage_in;

   logic              accept;
   logic              hit;
   logic              wrap;
   logic              at_origin;
   logic [IDX_W-1:0]  col_cur;
   logic [IDX_W-1:0]  row_cur;
   logic [SCAN_W-1:0] col_inc;
   logic [SCAN_W-1:0] width_eff;

   assign req_ready = !stage_ff.valid || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (cfg.grid_width == '0) begin
         width_eff = SCAN_W'(1);
      end else if (int'(cfg.grid_width) > GRID_DIM_MAX) begin
         width_eff = SCAN_W'(GRID_DIM_MAX);
      end else begin
         width_eff = SCAN_W'(cfg.grid_width);
      end
   end

   always_comb begin
      col_cur = req_data.frame_start ? '0 : scan_column_ff;
      row_cur = req_data.frame_start ? '0 : scan_row_ff;
      hit     = $signed(req_data.cell_value) >= $signed(cfg.hit_level);
      col_inc = SCAN_W'(col_cur) + SCAN_W'(1);
      wrap    = col_inc >= width_eff;

      scan_column_in = scan_column_ff;
      scan_row_in    = scan_row_ff;
      stage_in       = stage_ff;
      if (accept) begin
         if (wrap) begin
            scan_column_in = '0;
            scan_row_in    = (row_cur != ROW_LAST) ? row_cur + IDX_W'(1) : row_cur;
         end else begin
            scan_column_in = col_inc[IDX_W-1:0];
            scan_row_in    = row_cur;
         end
         stage_in.valid  = hit;
         stage_in.column = col_cur;
         stage_in.row    = row_cur;
      end else if (advance) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_column_ff <= '0;
         scan_row_ff    <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         scan_column_ff <= scan_column_in;
         scan_row_ff    <= scan_row_in;
         stage_ff       <= stage_in;
      end
   end

   assign stage = stage_ff;

   assign at_origin = (stage_ff.column == '0) && (stage_ff.row == '0);

   `ASSERT_NEXT(a_frame_start_origin, clock, reset, accept && req_data.frame_start, at_origin)
   `ASSERT_NEXT(a_stage_holds, clock, reset, stage_ff.valid && !advance, $stable(stage_ff))
   `ASSERT_IMPL(a_no_accept_when_blocked, clock, reset, stage_ff.valid && !advance, !req_ready)

endmodule

/* rtl/core/ocpe_map.sv */
// ----------------------------------------------------------------------------
// ocpe_map
// Affine map of the cell index into the base frame and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ocpe_map
   import ocpe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cell_stage_type stage,
   input  cfg_type        cfg,
   output logic           advance,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [COORD_W-1:0] col_ext;
   logic [COORD_W-1:0] row_ext;
   logic [COORD_W-1:0] col_x, col_y, row_x, row_y;

   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      col_ext = COORD_W'(stage.column);
      row_ext = COORD_W'(stage.row);
      col_x   = col_ext * cfg.column_step_x;
      col_y   = col_ext * cfg.column_step_y;
      row_x   = row_ext * cfg.row_step_x;
      row_y   = row_ext * cfg.row_step_y;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in            = stage.valid;
         rsp_data_in.point_x     = cfg.base_x + col_x + row_x;
         rsp_data_in.point_y     = cfg.base_y + col_y + row_y;
         rsp_data_in.cell_column = RSP_IDX_W'(stage.column);
         rsp_data_in.cell_row    = RSP_IDX_W'(stage.row);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEXT(a_hit_reaches_output, clock, reset, stage.valid && advance, rsp_valid_ff && rsp_data_ff.cell_row == RSP_IDX_W'($past(stage.row)))
   `ASSERT_NEXT(a_empty_stage_no_item, clock, reset, !stage.valid && advance, !rsp_valid_ff)

endmodule

/* rtl/core/occupied_cell_point_extractor.sv */
// ----------------------------------------------------------------------------
// occupied_cell_point_extractor
// Turns a raster stream of occupancy grid cells into base-frame points.
//
// req_*: one signed cell value per item, columns fastest, then rows;
//   frame_start marks cell (0,0) of a new grid and clears the scan.
// rsp_*: one item per cell at or above the threshold: Q15.16 point and the
//   cell's column and row. Cells below the threshold give nothing.
// csr_*: write-only registers, index as listed in ocpe_pkg; the user must
//   write them only while no item is in flight, the block does not enforce it.
// Path: from req accept to rsp_valid a cell passes the scan stage, then the
//   multiply-add into the result register.
// Throughput: one item per cycle while rsp_ready is high; the two stages
//   pass on together, each taking an item once the next empties or moves on.
// Stall: with rsp_ready low the result register holds, the scan stage holds
//   behind it and req_ready drops once both are full.
// Reset: counters cleared to cell (0,0), registers to their defaults, both
//   stages emptied. Usable the cycle after reset falls.
// ----------------------------------------------------------------------------
module occupied_cell_point_extractor
   import ocpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type        cfg;
   cell_stage_type stage;
   logic           advance;

   ocpe_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ocpe_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .advance   (advance),
      .stage     (stage)
   );

   ocpe_map u_map (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .cfg       (cfg),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* test/ocpe_checker.sv */
// ----------------------------------------------------------------------------
// ocpe_checker
// Watches the req, rsp and csr ports of the occupied cell point extractor.
// Keeps its own copy of the registers and the raster scan position, works
// out the point that each accepted cell should give, and compares every
// accepted rsp item field by field with the oldest point still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ocpe_checker
   import ocpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    mismatch_count,
   output int                    pending_points,
   output int                    checked_points
);

   cfg_type           regs;
   logic [SCAN_W-1:0] col_pos;
   logic [SCAN_W-1:0] row_pos;
   logic [SCAN_W-1:0] row_len;
   rsp_type           owed_points[$];

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s", msg);
   endtask

   always @(posedge clock) begin : track
      rsp_type            want;
      logic [COORD_W-1:0] col_w;
      logic [COORD_W-1:0] row_w;
      if (reset) begin
         regs = '0;
         regs.grid_width = GRID_WIDTH_RESET;
         regs.hit_level = THRESHOLD_RESET;
         col_pos = '0;
         row_pos = '0;
         owed_points.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_GRID_WIDTH:    regs.grid_width = csr_write_data[GRID_WIDTH_W-1:0];
               CSR_THRESHOLD:     regs.hit_level = csr_write_data[CELL_W-1:0];
               CSR_BASE_X:        regs.base_x = csr_write_data;
               CSR_BASE_Y:        regs.base_y = csr_write_data;
               CSR_COLUMN_STEP_X: regs.column_step_x = csr_write_data;
               CSR_COLUMN_STEP_Y: regs.column_step_y = csr_write_data;
               CSR_ROW_STEP_X:    regs.row_step_x = csr_write_data;
               CSR_ROW_STEP_Y:    regs.row_step_y = csr_write_data;
            endcase
         end

         // results leave before the new cell joins the queue
         if (rsp_valid && rsp_ready) begin
            checked_points++;
            if (owed_points.size() == 0) begin
               note_failure($sformatf("unexpected point x=%h y=%h col=%0d row=%0d",
                  rsp_data.point_x, rsp_data.point_y, rsp_data.cell_column,
                  rsp_data.cell_row));
            end else begin
               want = owed_points.pop_front();
               if (rsp_data.point_x !== want.point_x || rsp_data.point_y !== want.point_y ||
                   rsp_data.cell_column !== want.cell_column ||
                   rsp_data.cell_row !== want.cell_row) begin
                  note_failure($sformatf(
                     "mismatch: want x=%h y=%h c=%0d r=%0d, got x=%h y=%h c=%0d r=%0d",
                     want.point_x, want.point_y, want.cell_column, want.cell_row,
                     rsp_data.point_x, rsp_data.point_y, rsp_data.cell_column,
                     rsp_data.cell_row));
               end
            end
         end

         if (req_valid && req_ready) begin
            if (req_data.frame_start) begin
               col_pos = '0;
               row_pos = '0;
            end
            if (req_data.cell_value >= regs.hit_level) begin
               col_w = COORD_W'(col_pos);
               row_w = COORD_W'(row_pos);
               want.point_x = regs.base_x + col_w * regs.column_step_x
                              + row_w * regs.row_step_x;
               want.point_y = regs.base_y + col_w * regs.column_step_y
                              + row_w * regs.row_step_y;
               want.cell_column = col_pos[RSP_IDX_W-1:0];
               want.cell_row = row_pos[RSP_IDX_W-1:0];
               owed_points = {owed_points, want};
            end
            // zero width acts as one, oversize clamps to the grid maximum
            row_len = (regs.grid_width == 0) ? SCAN_W'(1) :
                      (regs.grid_width > GRID_DIM_MAX) ? SCAN_W'(GRID_DIM_MAX) :
                      regs.grid_width;
            if (col_pos + 1 >= row_len) begin
               col_pos = '0;
               if (row_pos < ROW_LAST)
                  row_pos++;
            end else begin
               col_pos++;
            end
         end
      end
      pending_points <= owed_points.size();
   end

endmodule

/* test/occupied_cell_point_extractor_tb.sv */
// ----------------------------------------------------------------------------
// occupied_cell_point_extractor_tb
// Stimulus and verdict for the occupied cell point extractor.
// A short directed sequence hits the threshold and value extremes, frame
// restarts, width clamping and a width cut mid-row; a long single-column
// sweep drives the row counter into saturation; then random register
// settings carry mostly well-formed raster frames with some noise. Both
// channels idle at random. ocpe_checker does the predicting and comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module occupied_cell_point_extractor_tb;
   import ocpe_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int mismatch_count;
   int pending_points;
   int checked_points;
   int items_sent;
   int phases;
   bit steady;

   occupied_cell_point_extractor uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   ocpe_checker point_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_points   (pending_points),
      .checked_points   (checked_points)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [CELL_W-1:0] random_cell();
      case ($urandom_range(0, 9))
         0, 1, 2:    return '1;
         3, 4, 5, 6: return CELL_W'($urandom_range(0, 100));
         default:    return CELL_W'($urandom);
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3, 4:    return COORD_W'($urandom_range(0, 1 << 18) - (1 << 17));
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      case ($urandom_range(0, 9))
         0:       s.grid_width = '0;
         1:       s.grid_width = GRID_WIDTH_W'(GRID_DIM_MAX);
         2:       s.grid_width = '1;
         3:       s.grid_width = GRID_WIDTH_W'($urandom_range(GRID_DIM_MAX + 1, 8191));
         4:       s.grid_width = GRID_WIDTH_W'($urandom_range(13, 300));
         default: s.grid_width = GRID_WIDTH_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
         0:       s.hit_level = -8'sd128;
         1:       s.hit_level = 8'sd127;
         2:       s.hit_level = -8'sd1;
         3:       s.hit_level = 8'sd0;
         4:       s.hit_level = THRESHOLD_RESET;
         default: s.hit_level = CELL_W'($urandom);
      endcase
      s.base_x = random_coord();
      s.base_y = random_coord();
      s.column_step_x = random_coord();
      s.column_step_y = random_coord();
      s.row_step_x = random_coord();
      s.row_step_y = random_coord();
      return s;
   endfunction

   // drain, let the pipeline empty, then write every register
   task automatic configure(input cfg_type s);
      logic [CSR_DATA_W-1:0] word;
      csr_index_type         reg_id;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_points != 0);
      repeat (4) @(posedge clock);
      reg_id = reg_id.first();
      do begin
         case (reg_id)
            CSR_GRID_WIDTH:
               word = {(CSR_DATA_W-GRID_WIDTH_W)'($urandom), s.grid_width};
            CSR_THRESHOLD:
               word = {(CSR_DATA_W-CELL_W)'($urandom), s.hit_level};
            CSR_BASE_X:        word = s.base_x;
            CSR_BASE_Y:        word = s.base_y;
            CSR_COLUMN_STEP_X: word = s.column_step_x;
            CSR_COLUMN_STEP_Y: word = s.column_step_y;
            CSR_ROW_STEP_X:    word = s.row_step_x;
            CSR_ROW_STEP_Y:    word = s.row_step_y;
         endcase
         csr_write_enable <= 1'b1;
         csr_index <= reg_id;
         csr_write_data <= word;
         @(posedge clock);
         reg_id = reg_id.next();
      end while (reg_id != reg_id.first());
      csr_write_enable <= 1'b0;
      phases++;
   endtask

   task automatic send_cell(input logic signed [CELL_W-1:0] value, input logic start);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cell_value: value, frame_start: start};
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      repeat (12) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      cfg_type s;
      int      left;
      int      burst;
      int      row_len;
      int      sweep_end;
      int      guard;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      steady = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // value extremes, threshold equality, frame restart mid-row
      s = '{grid_width: 13'd4, hit_level: 8'sd0,
            base_x: 32'h0001_8000, base_y: 32'hFFFE_8000,
            column_step_x: 32'h0001_0000, column_step_y: 32'h0000_4000,
            row_step_x: 32'hFFFF_C000, row_step_y: 32'h0002_0000};
      configure(s);
      send_cell(8'sd127, 1'b1);
      send_cell(-8'sd128, 1'b0);
      send_cell(-8'sd1, 1'b0);
      send_cell(8'sd0, 1'b0);
      send_cell(8'sd100, 1'b0);
      send_cell(8'sd1, 1'b0);
      send_cell(-8'sd2, 1'b0);
      send_cell(8'sd50, 1'b1);
      send_cell(8'sd0, 1'b0);

      // zero width, lowest threshold, wrapping coordinates
      s = '{grid_width: 13'd0, hit_level: -8'sd128,
            base_x: 32'h7FFF_FFFF, base_y: 32'h8000_0000,
            column_step_x: 32'h7FFF_FFFF, column_step_y: 32'h8000_0000,
            row_step_x: 32'h8000_0000, row_step_y: 32'h7FFF_FFFF};
      configure(s);
      send_cell(-8'sd128, 1'b1);
      send_cell(8'sd5, 1'b0);
      send_cell(-8'sd128, 1'b0);
      send_cell(8'sd127, 1'b0);

      // oversize width, highest threshold
      s.grid_width = '1;
      s.hit_level = 8'sd127;
      configure(s);
      send_cell(8'sd126, 1'b1);
      send_cell(8'sd127, 1'b0);
      send_cell(8'sd127, 1'b0);

      // width cut below the current column
      s = random_settings();
      s.grid_width = 13'd8;
      s.hit_level = -8'sd128;
      configure(s);
      for (int k = 0; k < 6; k++)
         send_cell(random_cell(), k == 0);
      s.grid_width = 13'd3;
      configure(s);
      for (int k = 0; k < 3; k++)
         send_cell(random_cell(), 1'b0);

      // one column, enough rows to pin the row counter at its top
      s = random_settings();
      s.grid_width = 13'd1;
      s.hit_level = THRESHOLD_RESET;
      configure(s);
      for (int k = 0; k < GRID_DIM_MAX + 8; k++) begin
         if (k >= GRID_DIM_MAX - 4 || $urandom_range(0, 63) == 0)
            send_cell(CELL_W'($urandom_range(100, 127)), k == 0);
         else
            send_cell(CELL_W'($urandom_range(0, 227) - 128), k == 0);
      end

      sweep_end = items_sent;
      while (items_sent - sweep_end < 1450) begin
         s = random_settings();
         configure(s);
         steady = ($urandom_range(0, 3) == 0);
         row_len = (s.grid_width == 0) ? 1 :
                   (s.grid_width > GRID_DIM_MAX) ? GRID_DIM_MAX : int'(s.grid_width);
         left = $urandom_range(60, 160);
         while (left > 0) begin
            if ($urandom_range(0, 99) < 85) begin
               burst = row_len * $urandom_range(1, 3);
               if ($urandom_range(0, 3) == 0)
                  burst += $urandom_range(0, row_len);
               for (int k = 0; k < burst && left > 0; k++) begin
                  send_cell(random_cell(), k == 0);
                  left--;
               end
            end else begin
               burst = $urandom_range(1, 20);
               for (int k = 0; k < burst && left > 0; k++) begin
                  send_cell(random_cell(), 1'($urandom_range(0, 1)));
                  left--;
               end
            end
         end
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending_points != 0 && guard < 50000);
      repeat (8) @(posedge clock);

      $display("%0d cells over %0d register settings, %0d points compared",
               items_sent, phases, checked_points);
      $display("covered value and threshold extremes, width clamping, row saturation");
      if (pending_points != 0)
         $display("%0d points never arrived", pending_points);
      if (mismatch_count == 0 && pending_points == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
